[hw/rtl/ctc_pkg.sv]
// Shared types and constants of the command token classifier.
// Used by ctc_scan, command_token_classifier, ctc_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package ctc_pkg;

   // Character codes that steer the scan.
   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_F     = 8'h46;

   // Token kinds.
   localparam logic [1:0] KIND_KEYWORD = 2'd0;
   localparam logic [1:0] KIND_NUMBER  = 2'd1;
   localparam logic [1:0] KIND_STRING  = 2'd2;

   // Keyword ids.
   localparam logic [1:0] KW_LOAD  = 2'd0;
   localparam logic [1:0] KW_STORE = 2'd1;
   localparam logic [1:0] KW_RESET = 2'd2;

   localparam int KW_COUNT = 3;
   localparam int KW_TEXT_DEPTH = 8;

   // Keyword spelling, padded with zeros beyond each keyword's length.
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_TEXT_DEPTH] = '{
      '{8'h6C, 8'h6F, 8'h61, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h73, 8'h74, 8'h6F, 8'h72, 8'h65, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h65, 8'h73, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd4, 4'd5, 4'd5};

   typedef struct packed {
      logic        token_valid;
      logic [1:0]  token_index;
      logic [1:0]  token_kind;
      logic [1:0]  keyword_id;
      logic [15:0] number_value;
      logic        end_of_string;
      logic [7:0]  token_total;
   } ctc_result_type;

endpackage

[hw/rtl/ctc_scan.sv]
// Per-character token scanner: keeps the token state and forms the result for a delimiter.
// Depends on ctc_pkg.
`timescale 1ns / 1ps

module ctc_scan #(
   parameter int MAX_TOKENS     = 3,
   parameter int MAX_HEX_DIGITS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic [7:0]              character,
   output logic                    result_valid,
   output ctc_pkg::ctc_result_type result
);

   localparam logic [7:0] TokLimit  = 8'(MAX_TOKENS);
   localparam logic [3:0] HexPosEnd = 4'(MAX_HEX_DIGITS + 2);

   logic        inside_ff, inside_in;
   logic [3:0]  pos_ff, pos_in;
   logic [2:0]  kw_alive_ff, kw_alive_in;
   logic        hex_alive_ff, hex_alive_in;
   logic [15:0] hex_acc_ff, hex_acc_in;
   logic [7:0]  tokens_ff, tokens_in;

   logic        is_end;
   logic        is_space;
   logic        reported;
   logic [1:0]  kind;
   logic [1:0]  kw_id;
   logic        is_hex;
   logic [3:0]  hex_digit;
   logic [3:0]  pos_eff;
   logic [2:0]  kw_eff;
   logic        hex_eff;
   logic [15:0] acc_eff;
   logic        in_digits;

   assign is_end   = (character == ctc_pkg::CHAR_END);
   assign is_space = (character == ctc_pkg::CHAR_SPACE);
   // A token is reported only while the token count is at most the limit.
   assign reported = inside_ff && (tokens_ff <= TokLimit);

   // Classify the token that a delimiter ends; the lowest matching keyword wins.
   always_comb begin
      kind  = ctc_pkg::KIND_STRING;
      kw_id = ctc_pkg::KW_LOAD;
      if (hex_alive_ff && (pos_ff >= 4'd3)) begin
         kind = ctc_pkg::KIND_NUMBER;
      end
      for (int k = ctc_pkg::KW_COUNT - 1; k >= 0; k--) begin
         if (kw_alive_ff[k] && (pos_ff == ctc_pkg::KW_LEN[k])) begin
            kind  = ctc_pkg::KIND_KEYWORD;
            kw_id = 2'(k);
         end
      end
   end

   always_comb begin
      result.token_valid   = reported;
      result.token_index   = reported ? 2'(tokens_ff - 8'd1) : 2'd0;
      result.token_kind    = reported ? kind : ctc_pkg::KIND_KEYWORD;
      result.keyword_id    = (reported && (kind == ctc_pkg::KIND_KEYWORD)) ? kw_id : 2'd0;
      result.number_value  = (reported && (kind == ctc_pkg::KIND_NUMBER)) ? hex_acc_ff : 16'd0;
      result.end_of_string = is_end;
      result.token_total   = is_end ? tokens_ff : 8'd0;
   end

   assign result_valid = is_end || (is_space && reported);

   // Upper-case hex digit decode.
   always_comb begin
      is_hex    = 1'b0;
      hex_digit = 4'd0;
      if ((character >= ctc_pkg::CHAR_ZERO) && (character <= ctc_pkg::CHAR_NINE)) begin
         is_hex    = 1'b1;
         hex_digit = 4'(character - ctc_pkg::CHAR_ZERO);
      end else if ((character >= ctc_pkg::CHAR_A) && (character <= ctc_pkg::CHAR_F)) begin
         is_hex    = 1'b1;
         hex_digit = 4'(character - ctc_pkg::CHAR_A) + 4'd10;
      end
   end

   // The first character of a token starts from a cleared token state.
   assign pos_eff   = inside_ff ? pos_ff : 4'd0;
   assign kw_eff    = inside_ff ? kw_alive_ff : 3'b111;
   assign hex_eff   = inside_ff ? hex_alive_ff : 1'b1;
   assign acc_eff   = inside_ff ? hex_acc_ff : 16'd0;
   assign in_digits = (pos_eff >= 4'd2) && (pos_eff < HexPosEnd);

   always_comb begin
      inside_in   = inside_ff;
      pos_in      = pos_ff;
      kw_alive_in = kw_alive_ff;
      hex_alive_in = hex_alive_ff;
      hex_acc_in  = hex_acc_ff;
      tokens_in   = tokens_ff;
      if (take) begin
         if (is_end) begin
            inside_in    = 1'b0;
            pos_in       = 4'd0;
            kw_alive_in  = 3'b111;
            hex_alive_in = 1'b1;
            hex_acc_in   = 16'd0;
            tokens_in    = 8'd0;
         end else if (is_space) begin
            inside_in = 1'b0;
         end else begin
            inside_in = 1'b1;
            if (!inside_ff && (tokens_ff != 8'hFF)) begin
               tokens_in = tokens_ff + 8'd1;
            end
            for (int k = 0; k < ctc_pkg::KW_COUNT; k++) begin
               kw_alive_in[k] = kw_eff[k] && (pos_eff < ctc_pkg::KW_LEN[k])
                  && (ctc_pkg::KW_TEXT[k][pos_eff[2:0]] == character);
            end
            if (!hex_eff) begin
               hex_alive_in = 1'b0;
            end else if (pos_eff == 4'd0) begin
               hex_alive_in = (character == ctc_pkg::CHAR_ZERO);
            end else if (pos_eff == 4'd1) begin
               hex_alive_in = (character == ctc_pkg::CHAR_X);
            end else begin
               hex_alive_in = in_digits && is_hex;
            end
            hex_acc_in = (hex_eff && in_digits && is_hex) ? {acc_eff[11:0], hex_digit}
                                                          : acc_eff;
            pos_in = (pos_eff == 4'hF) ? pos_eff : pos_eff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         pos_ff       <= 4'd0;
         kw_alive_ff  <= 3'b111;
         hex_alive_ff <= 1'b1;
         hex_acc_ff   <= 16'd0;
         tokens_ff    <= 8'd0;
      end else begin
         inside_ff    <= inside_in;
         pos_ff       <= pos_in;
         kw_alive_ff  <= kw_alive_in;
         hex_alive_ff <= hex_alive_in;
         hex_acc_ff   <= hex_acc_in;
         tokens_ff    <= tokens_in;
      end
   end

endmodule

[hw/rtl/command_token_classifier.sv]
// Top level of the command token classifier: scanner plus a two-entry result buffer.
// Depends on ctc_pkg and ctc_scan.
`timescale 1ns / 1ps

// Usage:
// The req_ channel carries one command byte per beat. A space separates tokens and a
// zero byte ends the string. The rsp_ channel carries at most one beat per request
// beat: a token report when a space ends a reportable token, and an end beat with
// rsp_end_of_string high for every zero byte, which also reports a token it ends.
// Only the first MAX_TOKENS tokens of a string are reported; all are counted up to 255.
// A result is registered in the result buffer before it is presented on rsp_. The
// scanner takes one request beat per cycle while req_ready is high.
// The result path holds an output register and one skid entry, so req_ready stays
// high while one finished result waits; it drops only when both entries are full.
// Reset clears the token state and empties the result buffer; the next byte starts
// a new string.

module command_token_classifier #(
   parameter int MAX_TOKENS     = 3,
   parameter int MAX_HEX_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_character,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_token_valid,
   output logic [1:0]  rsp_token_index,
   output logic [1:0]  rsp_token_kind,
   output logic [1:0]  rsp_keyword_id,
   output logic [15:0] rsp_number_value,
   output logic        rsp_end_of_string,
   output logic [7:0]  rsp_token_total
);

   logic                    accept;
   logic                    scan_valid;
   ctc_pkg::ctc_result_type scan_result;
   logic                    new_res;
   logic                    out_free;

   logic                    out_valid_ff, out_valid_in;
   ctc_pkg::ctc_result_type out_ff, out_in;
   logic                    skid_valid_ff, skid_valid_in;
   ctc_pkg::ctc_result_type skid_ff, skid_in;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign new_res   = accept && scan_valid;
   assign out_free  = !out_valid_ff || rsp_ready;

   ctc_scan #(
      .MAX_TOKENS     (MAX_TOKENS),
      .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .take         (accept),
      .character    (req_character),
      .result_valid (scan_valid),
      .result       (scan_result)
   );

   // The skid entry is always older than a new result, so it moves up first.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = new_res;
            skid_in       = scan_result;
         end else begin
            out_valid_in = new_res;
            out_in       = scan_result;
         end
      end else if (new_res) begin
         skid_valid_in = 1'b1;
         skid_in       = scan_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_token_valid   = out_ff.token_valid;
   assign rsp_token_index   = out_ff.token_index;
   assign rsp_token_kind    = out_ff.token_kind;
   assign rsp_keyword_id    = out_ff.keyword_id;
   assign rsp_number_value  = out_ff.number_value;
   assign rsp_end_of_string = out_ff.end_of_string;
   assign rsp_token_total   = out_ff.token_total;

endmodule

[hw/rtl/ctc_checker.sv]
// Port-level checks for command_token_classifier, attached by the bind at the end.
// Depends on ctc_pkg.
`timescale 1ns / 1ps

module ctc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_token_valid,
   input logic [1:0]  rsp_token_kind,
   input logic [1:0]  rsp_keyword_id,
   input logic [15:0] rsp_number_value,
   input logic        rsp_end_of_string,
   input logic [7:0]  rsp_token_total
);

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_number_value) && $stable(rsp_token_total))
      else $error("stalled result beat changed");

   // With nothing on the result side, the buffer has room for a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result buffer");

   // A beat without a token report can only be the end of a string.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_token_valid |-> rsp_end_of_string)
      else $error("empty result beat that is not the end of a string");

   // The token count is shown only on the end beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_string |-> rsp_token_total == 8'd0)
      else $error("token count shown before end of string");

   // The number value and keyword id belong to their own kinds only.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_token_kind == ctc_pkg::KIND_NUMBER || rsp_number_value == 16'd0)
         && (rsp_token_kind == ctc_pkg::KIND_KEYWORD || rsp_keyword_id == 2'd0))
      else $error("number value or keyword id set for another kind");

endmodule

bind command_token_classifier ctc_checker u_ctc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_token_valid   (rsp_token_valid),
   .rsp_token_kind    (rsp_token_kind),
   .rsp_keyword_id    (rsp_keyword_id),
   .rsp_number_value  (rsp_number_value),
   .rsp_end_of_string (rsp_end_of_string),
   .rsp_token_total   (rsp_token_total)
);

[tb/sv/testbench.sv]
// Self-checking testbench for command_token_classifier: streams command strings on req_,
// predicts every token report and end beat, and checks rsp_ beats in order.
// Depends on ctc_pkg and the RTL of the classifier.
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_TOKENS     = 3;
   localparam int MAX_HEX_DIGITS = 4;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam int SEGMENT_BEATS  = 10;
   localparam int CROWDED_TOKENS = 260;
   localparam int MAX_PRINTED    = 50;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_character = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_token_valid;
   logic [1:0]  rsp_token_index;
   logic [1:0]  rsp_token_kind;
   logic [1:0]  rsp_keyword_id;
   logic [15:0] rsp_number_value;
   logic        rsp_end_of_string;
   logic [7:0]  rsp_token_total;

   logic [7:0] char_queue [$];
   int         chars_queued = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic       req_taken = 1'b0;
   int         error_count = 0;

   // Shadow copy of the scanner state.
   logic        in_token;
   logic [3:0]  tok_len;
   logic [2:0]  kw_match;
   logic        hex_ok;
   logic [15:0] hex_value;
   logic [7:0]  token_count;

   ctc_pkg::ctc_result_type expected_reports [$];
   ctc_pkg::ctc_result_type predicted;
   ctc_pkg::ctc_result_type oldest;

   command_token_classifier #(
      .MAX_TOKENS     (MAX_TOKENS),
      .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_character     (req_character),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_valid   (rsp_token_valid),
      .rsp_token_index   (rsp_token_index),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_keyword_id    (rsp_keyword_id),
      .rsp_number_value  (rsp_number_value),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_token_total   (rsp_token_total)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic void clear_token();
      in_token  = 1'b0;
      tok_len   = '0;
      kw_match  = '1;
      hex_ok    = 1'b1;
      hex_value = '0;
   endfunction

   // Advances the shadow scanner by one character; returns 1 when the beat yields a result.
   function automatic bit classify_char(input logic [7:0] c,
                                        output ctc_pkg::ctc_result_type r);
      int         pos;
      int         idx;
      int         k;
      bit         reported;
      logic [3:0] digit;
      r = '0;
      reported = 1'b0;
      if (c == ctc_pkg::CHAR_END || c == ctc_pkg::CHAR_SPACE) begin
         idx = int'(token_count) - 1;
         if (in_token && idx >= 0 && idx < MAX_TOKENS) begin
            reported = 1'b1;
            r.token_valid = 1'b1;
            r.token_index = idx[1:0];
            r.token_kind = ctc_pkg::KIND_STRING;
            if (hex_ok && tok_len >= 3) begin
               r.token_kind = ctc_pkg::KIND_NUMBER;
               r.number_value = hex_value;
            end
            for (k = ctc_pkg::KW_COUNT - 1; k >= 0; k--) begin
               if (kw_match[k] && tok_len == ctc_pkg::KW_LEN[k]) begin
                  r.token_kind = ctc_pkg::KIND_KEYWORD;
                  r.keyword_id = 2'(k);
                  r.number_value = '0;
               end
            end
         end
         in_token = 1'b0;
         if (c == ctc_pkg::CHAR_END) begin
            r.end_of_string = 1'b1;
            r.token_total = token_count;
            clear_token();
            token_count = '0;
            return 1'b1;
         end
         return reported;
      end

      if (!in_token) begin
         clear_token();
         in_token = 1'b1;
         if (token_count != 8'hFF) token_count++;
      end
      pos = int'(tok_len);
      for (k = 0; k < ctc_pkg::KW_COUNT; k++) begin
         if (pos >= ctc_pkg::KW_LEN[k] || ctc_pkg::KW_TEXT[k][pos] != c) kw_match[k] = 1'b0;
      end
      if (hex_ok) begin
         if (pos == 0) begin
            if (c != ctc_pkg::CHAR_ZERO) hex_ok = 1'b0;
         end else if (pos == 1) begin
            if (c != ctc_pkg::CHAR_X) hex_ok = 1'b0;
         end else if (pos - 2 >= MAX_HEX_DIGITS) begin
            hex_ok = 1'b0;
         end else if (c >= ctc_pkg::CHAR_ZERO && c <= ctc_pkg::CHAR_NINE) begin
            digit = 4'(c - ctc_pkg::CHAR_ZERO);
            hex_value = {hex_value[11:0], digit};
         end else if (c >= ctc_pkg::CHAR_A && c <= ctc_pkg::CHAR_F) begin
            digit = 4'(c - ctc_pkg::CHAR_A + 8'd10);
            hex_value = {hex_value[11:0], digit};
         end else begin
            hex_ok = 1'b0;
         end
      end
      if (tok_len != 4'hF) tok_len++;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   // Monitor: checks result beats, then predicts from the request beat of the same edge.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         clear_token();
         token_count = '0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("result beat with no expectation waiting");
            end else begin
               oldest = expected_reports.pop_front();
               check_field("token_valid", 16'(rsp_token_valid), 16'(oldest.token_valid));
               check_field("token_index", 16'(rsp_token_index), 16'(oldest.token_index));
               check_field("token_kind", 16'(rsp_token_kind), 16'(oldest.token_kind));
               check_field("keyword_id", 16'(rsp_keyword_id), 16'(oldest.keyword_id));
               check_field("number_value", rsp_number_value, oldest.number_value);
               check_field("end_of_string", 16'(rsp_end_of_string),
                           16'(oldest.end_of_string));
               check_field("token_total", 16'(rsp_token_total), 16'(oldest.token_total));
            end
         end
         if (req_valid && req_ready) begin
            if (classify_char(req_character, predicted)) expected_reports.push_back(predicted);
         end
      end
   end

   // Driver: a pending beat holds until taken; the next one may be delayed by an idle roll.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_character <= char_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic queue_char(input logic [7:0] c);
      char_queue.push_back(c);
      chars_queued++;
   endtask

   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) queue_char(s[i]);
   endtask

   function automatic logic [7:0] random_token_char();
      logic [7:0] c;
      c = ctc_pkg::CHAR_SPACE;
      while (c == ctc_pkg::CHAR_SPACE || c == ctc_pkg::CHAR_END) c = 8'($urandom_range(255));
      return c;
   endfunction

   task automatic queue_token();
      int         choice;
      int         k;
      int         variant;
      int         cut;
      int         bad;
      int         len;
      int         mode;
      int         d;
      int         i;
      logic [7:0] c;
      choice = $urandom_range(99);
      if (choice < 30) begin
         // Keywords, exact or bent: cut short, one letter changed, or one letter added.
         k = $urandom_range(ctc_pkg::KW_COUNT - 1);
         variant = $urandom_range(4);
         cut = (variant == 2) ? $urandom_range(1, ctc_pkg::KW_LEN[k] - 1)
                              : int'(ctc_pkg::KW_LEN[k]);
         bad = (variant == 3) ? $urandom_range(ctc_pkg::KW_LEN[k] - 1) : -1;
         for (i = 0; i < cut; i++) begin
            queue_char((i == bad) ? random_token_char() : ctc_pkg::KW_TEXT[k][i]);
         end
         if (variant == 4) queue_char(random_token_char());
      end else if (choice < 65) begin
         queue_char(ctc_pkg::CHAR_ZERO);
         queue_char(($urandom_range(9) == 0) ? random_token_char() : ctc_pkg::CHAR_X);
         len = $urandom_range(MAX_HEX_DIGITS + 2);
         mode = $urandom_range(9);
         for (i = 0; i < len; i++) begin
            d = $urandom_range(15);
            if (mode == 0) d = 15;
            else if (mode == 1) d = 0;
            if ($urandom_range(11) == 0) c = 8'(CHAR_LOWER_A + $urandom_range(5));
            else if ($urandom_range(15) == 0) c = random_token_char();
            else c = (d < 10) ? 8'(ctc_pkg::CHAR_ZERO + d) : 8'(ctc_pkg::CHAR_A + d - 10);
            queue_char(c);
         end
      end else begin
         // Plain strings; some run past the saturation of the character position.
         len = ($urandom_range(4) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
         for (i = 0; i < len; i++) queue_char(random_token_char());
      end
   endtask

   task automatic queue_command();
      int n;
      int i;
      if ($urandom_range(9) == 0) begin
         // Raw noise: any byte, spaces and zero bytes included.
         n = $urandom_range(1, 12);
         for (i = 0; i < n; i++) queue_char(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(5) == 0) queue_char(ctc_pkg::CHAR_SPACE);
         n = $urandom_range(5);
         for (i = 0; i < n; i++) begin
            queue_token();
            if (i != n - 1 || $urandom_range(4) == 0) begin
               repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 1) begin
                  queue_char(ctc_pkg::CHAR_SPACE);
               end
            end
         end
         queue_char(ctc_pkg::CHAR_END);
      end
   endtask

   initial begin : stimulus
      int segment;
      int target;
      int i;
      // Empty string, then a string with a leading space, every token kind, the byte
      // extremes and a fourth token cut off by the terminator, then a bare 0x.
      queue_char(ctc_pkg::CHAR_END);
      queue_text(" reset 0x0 ");
      queue_char(8'hFF);
      queue_char(8'h01);
      queue_text(" load");
      queue_char(ctc_pkg::CHAR_END);
      queue_text("0x");
      queue_char(ctc_pkg::CHAR_END);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (char_queue.size() != 0) @(posedge clock);

      for (segment = 0; segment < 8; segment++) begin
         case (segment % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 56;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 56;
            end
            default: begin
               send_idle_pct = 31;
               recv_stall_pct = 31;
            end
         endcase
         target = chars_queued + SEGMENT_BEATS;
         if (segment == 5) begin
            // One string with more tokens than the count can hold.
            for (i = 0; i < CROWDED_TOKENS; i++) begin
               queue_char(random_token_char());
               queue_char(ctc_pkg::CHAR_SPACE);
            end
            queue_char(ctc_pkg::CHAR_END);
         end
         while (chars_queued < target) queue_command();
         while (char_queue.size() != 0) @(posedge clock);
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (req_valid) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
